>>> sv/aaspt_pkg.sv
package aaspt_pkg;

   localparam int COORD_BITS = 32;
   localparam int FIELD_BITS = 32;
   localparam int SLACK_BITS = 31;
   localparam int CODE_BITS  = 10;
   localparam int DW = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 3;

   localparam logic [2:0] REG_MIN_X = 3'd0;
   localparam logic [2:0] REG_MIN_Y = 3'd1;
   localparam logic [2:0] REG_MIN_Z = 3'd2;
   localparam logic [2:0] REG_MAX_X = 3'd3;
   localparam logic [2:0] REG_MAX_Y = 3'd4;
   localparam logic [2:0] REG_MAX_Z = 3'd5;
   localparam logic [2:0] REG_SLACK = 3'd6;
   localparam logic [2:0] REG_CODE  = 3'd7;

   localparam logic [2:0] CLS_LINE  = 3'd0;
   localparam logic [2:0] CLS_QUAD  = 3'd1;
   localparam logic [2:0] CLS_HEX   = 3'd2;
   localparam logic [2:0] CLS_TRI   = 3'd3;
   localparam logic [2:0] CLS_TET   = 3'd4;
   localparam logic [2:0] CLS_PRISM = 3'd5;

   localparam logic [1:0] PLANE_XY = 2'd0;
   localparam logic [1:0] PLANE_XZ = 2'd1;
   localparam logic [1:0] PLANE_YZ = 2'd2;

   localparam logic [1:0] PLANE_A [3] = '{2'd0, 2'd0, 2'd1};
   localparam logic [1:0] PLANE_B [3] = '{2'd1, 2'd2, 2'd2};

   localparam logic [2:0] TET_TYPE_MAP [6][6] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
      '{3'd1, 3'd0, 3'd5, 3'd4, 3'd3, 3'd2},
      '{3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1},
      '{3'd3, 3'd2, 3'd1, 3'd0, 3'd5, 3'd4},
      '{3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3},
      '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}
   };

   localparam logic TET_FORM [6][2] = '{
      '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b0},
      '{1'b1, 1'b0}, '{1'b1, 1'b1}, '{1'b0, 1'b1}
   };

   localparam logic [1:0] TET_PLANE [6][2] = '{
      '{PLANE_XZ, PLANE_YZ}, '{PLANE_XY, PLANE_YZ}, '{PLANE_XY, PLANE_XZ},
      '{PLANE_XZ, PLANE_YZ}, '{PLANE_XY, PLANE_YZ}, '{PLANE_XY, PLANE_XZ}
   };

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] point_x;
      logic signed [FIELD_BITS-1:0] point_y;
      logic signed [FIELD_BITS-1:0] point_z;
      logic                         batch_end;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic shape_error;
      logic batch_end_out;
   } rsp_type;

   typedef struct packed {
      logic [2:0][DW-1:0] mn;
      logic [2:0][DW-1:0] lo;
      logic [2:0][DW-1:0] hi;
      logic [DW-1:0]      tol;
      logic [2:0]         need0;
      logic [2:0]         need1;
      logic               err;
   } shape_type;

   function automatic logic [DW-1:0] coord_ext(input logic [FIELD_BITS-1:0] f);
      logic [COORD_BITS+FIELD_BITS-1:0] w;
      logic [COORD_BITS-1:0]            c;
      w = {{COORD_BITS{1'b0}}, f};
      c = w[COORD_BITS-1:0];
      return {{(DW-COORD_BITS){c[COORD_BITS-1]}}, c};
   endfunction

   function automatic logic [DW-1:0] slack_ext(input logic [SLACK_BITS-1:0] s);
      return {{(DW-SLACK_BITS){1'b0}}, s};
   endfunction

endpackage

>>> sv/aaspt_pipe.sv
module aaspt_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aaspt_pkg::req_type   req_data,
   input  aaspt_pkg::shape_type shape,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aaspt_pkg::rsp_type   rsp_data
);

   logic adv1, adv2, adv3, adv4;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;

   aaspt_pkg::req_type p1_ff, p1_in;

   logic [2:0][aaspt_pkg::DW-1:0] d2_ff, d2_in;
   logic                          box2_ff, box2_in;
   logic                          be2_ff, be2_in;

   logic [2:0][aaspt_pkg::DW-1:0] q3_ff, q3_in;
   logic                          box3_ff, box3_in;
   logic                          be3_ff, be3_in;

   aaspt_pkg::rsp_type rsp_ff, rsp_in;

   logic [2:0][aaspt_pkg::DW-1:0] pe;
   logic [2:0]                    box_ok;
   logic [2:0][aaspt_pkg::DW-1:0] q;
   logic [2:0][aaspt_pkg::DW-1:0] qsum;
   logic [2:0]                    pass0, pass1;
   logic                          inside_ok;

   assign adv4 = !v4_ff || !rsp_stall;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   assign p1_in = adv1 ? req_data : p1_ff;

   always_comb begin
      pe[0] = aaspt_pkg::coord_ext(p1_ff.point_x);
      pe[1] = aaspt_pkg::coord_ext(p1_ff.point_y);
      pe[2] = aaspt_pkg::coord_ext(p1_ff.point_z);
      for (int i = 0; i < 3; i++) begin
         q[i] = pe[i] - shape.mn[i];
         box_ok[i] = ($signed(pe[i]) >= $signed(shape.lo[i]))
                  && ($signed(pe[i]) <= $signed(shape.hi[i]));
      end
      d2_in   = adv2 ? q : d2_ff;
      box2_in = adv2 ? (&box_ok) : box2_ff;
      be2_in  = adv2 ? p1_ff.batch_end : be2_ff;
   end

   always_comb begin
      q3_in = q3_ff;
      if (adv3) begin
         for (int i = 0; i < 3; i++) begin
            q3_in[i] = d2_ff[aaspt_pkg::PLANE_A[i]] - d2_ff[aaspt_pkg::PLANE_B[i]];
         end
      end
      box3_in = adv3 ? box2_ff : box3_ff;
      be3_in  = adv3 ? be2_ff : be3_ff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qsum[i]  = q3_ff[i] + shape.tol;
         pass0[i] = !qsum[i][aaspt_pkg::DW-1];
         pass1[i] = $signed(q3_ff[i]) <= $signed(shape.tol);
      end
      inside_ok = box3_ff && !shape.err
               && (&(~shape.need0 | pass0)) && (&(~shape.need1 | pass1));
      rsp_in = rsp_ff;
      if (adv4) begin
         rsp_in.inside_res    = inside_ok;
         rsp_in.shape_error   = shape.err;
         rsp_in.batch_end_out = be3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      d2_ff   <= d2_in;
      box2_ff <= box2_in;
      be2_ff  <= be2_in;
      q3_ff   <= q3_in;
      box3_ff <= box3_in;
      be3_ff  <= be3_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

   a_err_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.shape_error |-> !rsp_data.inside_res)
      else $error("shape error with inside result");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff)
      else $error("input stalled with a bubble in the pipeline");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp_stall |=> v4_ff)
      else $error("transaction lost between last stages");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && rsp_stall |=> v4_ff && $stable(rsp_ff))
      else $error("stalled result changed");

endmodule

>>> sv/axis_aligned_simplex_point_test.sv
// Point-in-element test for an axis-aligned element, one point per transaction.
// Input channel req_*: req_valid/req_stall with req_data holding point_x/y/z
// (signed Q16.16) and batch_end. Result channel rsp_*: rsp_valid/rsp_stall with
// rsp_data holding inside_res, shape_error and batch_end_out.
// Configuration csr_*: write csr_wdata to register csr_index when csr_write is
// high (0..5 corners min x/y/z, max x/y/z, 6 slack, 7 shape code). Write only
// while no transaction is in flight; derived bounds are registered again after them.
// A point accepted on req_* reaches rsp_data through four register stages:
// input, axis differences and box check, plane differences, half-plane check
// and result register. Throughput: one point per cycle unless the receiver
// stalls; the rate is set by the stage handshake.
// Reset (synchronous, active high) clears the configuration registers to zero
// and empties the pipeline. When the receiver stalls, the result holds and the
// stages fill in turn; req_stall rises only once every stage holds a transaction.
module axis_aligned_simplex_point_test (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  aaspt_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output aaspt_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_write,
   input  logic [2:0]                           csr_index,
   input  logic [aaspt_pkg::FIELD_BITS-1:0]     csr_wdata
);

   logic [2:0][aaspt_pkg::FIELD_BITS-1:0] min_ff, min_in;
   logic [2:0][aaspt_pkg::FIELD_BITS-1:0] max_ff, max_in;
   logic [aaspt_pkg::SLACK_BITS-1:0]      slack_ff, slack_in;
   logic [aaspt_pkg::CODE_BITS-1:0]       code_ff, code_in;

   aaspt_pkg::shape_type shape_ff, shape_in;

   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      slack_in = slack_ff;
      code_in  = code_ff;
      if (csr_write) begin
         unique case (csr_index)
            aaspt_pkg::REG_MIN_X: min_in[0] = csr_wdata;
            aaspt_pkg::REG_MIN_Y: min_in[1] = csr_wdata;
            aaspt_pkg::REG_MIN_Z: min_in[2] = csr_wdata;
            aaspt_pkg::REG_MAX_X: max_in[0] = csr_wdata;
            aaspt_pkg::REG_MAX_Y: max_in[1] = csr_wdata;
            aaspt_pkg::REG_MAX_Z: max_in[2] = csr_wdata;
            aaspt_pkg::REG_SLACK: slack_in = csr_wdata[aaspt_pkg::SLACK_BITS-1:0];
            aaspt_pkg::REG_CODE:  code_in = csr_wdata[aaspt_pkg::CODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [2:0]                    cls, tree_raw, tree6, et_raw, et6, tsel;
      logic                          orient;
      logic [2:0][aaspt_pkg::DW-1:0] mn_e, mx_e;
      logic [1:0]                    pl0, pl1;
      logic                          fm0, fm1;
      cls      = code_ff[2:0];
      tree_raw = code_ff[5:3];
      et_raw   = code_ff[8:6];
      tree6    = (tree_raw >= 3'd6) ? tree_raw - 3'd6 : tree_raw;
      et6      = (et_raw >= 3'd6) ? et_raw - 3'd6 : et_raw;
      tsel     = code_ff[9] ? tree6 : aaspt_pkg::TET_TYPE_MAP[tree6][et6];
      orient   = tree6[0] ^ et_raw[0];
      pl0      = aaspt_pkg::TET_PLANE[tsel][0];
      pl1      = aaspt_pkg::TET_PLANE[tsel][1];
      fm0      = aaspt_pkg::TET_FORM[tsel][0];
      fm1      = aaspt_pkg::TET_FORM[tsel][1];
      shape_in.tol = aaspt_pkg::slack_ext(slack_ff);
      for (int i = 0; i < 3; i++) begin
         mn_e[i] = aaspt_pkg::coord_ext(min_ff[i]);
         mx_e[i] = aaspt_pkg::coord_ext(max_ff[i]);
         shape_in.mn[i] = mn_e[i];
         shape_in.lo[i] = mn_e[i] - shape_in.tol;
         shape_in.hi[i] = mx_e[i] + shape_in.tol;
      end
      shape_in.need0 = 3'b000;
      shape_in.need1 = 3'b000;
      shape_in.err   = 1'b0;
      unique case (cls) inside
         aaspt_pkg::CLS_LINE, aaspt_pkg::CLS_QUAD, aaspt_pkg::CLS_HEX: ;
         aaspt_pkg::CLS_PRISM: begin
            if (orient) shape_in.need1[aaspt_pkg::PLANE_XY] = 1'b1;
            else shape_in.need0[aaspt_pkg::PLANE_XY] = 1'b1;
         end
         aaspt_pkg::CLS_TRI: begin
            if (mn_e[2] == mx_e[2]) begin
               if (orient) shape_in.need1[aaspt_pkg::PLANE_XY] = 1'b1;
               else shape_in.need0[aaspt_pkg::PLANE_XY] = 1'b1;
            end else if (mn_e[1] == mx_e[1]) begin
               if (orient) shape_in.need1[aaspt_pkg::PLANE_XZ] = 1'b1;
               else shape_in.need0[aaspt_pkg::PLANE_XZ] = 1'b1;
            end else if (mn_e[0] == mx_e[0]) begin
               if (orient) shape_in.need1[aaspt_pkg::PLANE_YZ] = 1'b1;
               else shape_in.need0[aaspt_pkg::PLANE_YZ] = 1'b1;
            end else begin
               shape_in.err = 1'b1;
            end
         end
         aaspt_pkg::CLS_TET: begin
            if (fm0) shape_in.need1[pl0] = 1'b1;
            else shape_in.need0[pl0] = 1'b1;
            if (fm1) shape_in.need1[pl1] = 1'b1;
            else shape_in.need0[pl1] = 1'b1;
         end
         default: shape_in.err = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '0;
         max_ff   <= '0;
         slack_ff <= '0;
         code_ff  <= '0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         slack_ff <= slack_in;
         code_ff  <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      shape_ff <= shape_in;
   end

   aaspt_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .shape     (shape_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/axis_aligned_simplex_point_test_tb.sv
module axis_aligned_simplex_point_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0][31:0] lo;
      logic [2:0][31:0] hi;
      logic [30:0]      slack;
      logic [9:0]       code;
   } setup_type;

   localparam longint COORD_LOW  = -64'sd2147483648;
   localparam longint COORD_HIGH = 64'sd2147483647;

   localparam int TYPE_REMAP [6][6] = '{
      '{0, 1, 2, 3, 4, 5},
      '{1, 0, 5, 4, 3, 2},
      '{2, 3, 4, 5, 0, 1},
      '{3, 2, 1, 0, 5, 4},
      '{4, 5, 0, 1, 2, 3},
      '{5, 4, 3, 2, 1, 0}
   };
   localparam bit FACE_FORM [6][2] = '{
      '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b0},
      '{1'b1, 1'b0}, '{1'b1, 1'b1}, '{1'b0, 1'b1}
   };
   localparam int FACE_PLANE [6][2] = '{
      '{1, 2}, '{0, 2}, '{0, 1}, '{1, 2}, '{0, 2}, '{0, 1}
   };
   localparam int PLANE_AXIS [3][2] = '{'{0, 1}, '{0, 2}, '{1, 2}};
   localparam logic [2:0] REG_ORDER [8] = '{
      aaspt_pkg::REG_MIN_X, aaspt_pkg::REG_MIN_Y, aaspt_pkg::REG_MIN_Z,
      aaspt_pkg::REG_MAX_X, aaspt_pkg::REG_MAX_Y, aaspt_pkg::REG_MAX_Z,
      aaspt_pkg::REG_SLACK, aaspt_pkg::REG_CODE
   };

   class ledger_type;
      setup_type          setup;
      aaspt_pkg::req_type points_q[$];
      aaspt_pkg::rsp_type verdicts_q[$];
      int                 mismatches;

      function new();
         setup      = '0;
         mismatches = 0;
      endfunction

      function bit half_plane(longint c[3], int a, int b, bit form, longint tol);
         if (form == 1'b0) return (c[b] - tol <= c[a]);
         return (c[a] - tol <= c[b]);
      endfunction

      function aaspt_pkg::rsp_type containment_of(aaspt_pkg::req_type p);
         longint             pt[3];
         longint             lo[3];
         longint             hi[3];
         longint             c[3];
         longint             tol;
         logic [2:0]         cls;
         logic [2:0]         tree;
         logic [2:0]         etype;
         bit                 lvl0;
         bit                 orient;
         bit                 flat;
         int                 a;
         int                 b;
         int                 t;
         aaspt_pkg::rsp_type r;
         pt[0] = longint'($signed(p.point_x));
         pt[1] = longint'($signed(p.point_y));
         pt[2] = longint'($signed(p.point_z));
         tol   = longint'(setup.slack);
         cls   = setup.code[2:0];
         tree  = setup.code[5:3];
         etype = setup.code[8:6];
         lvl0  = setup.code[9];
         if (tree >= 3'd6) tree = tree - 3'd6;
         orient = tree[0] ^ etype[0];
         r.inside_res    = 1'b1;
         r.shape_error   = 1'b0;
         r.batch_end_out = p.batch_end;
         for (int i = 0; i < 3; i++) begin
            lo[i] = longint'($signed(setup.lo[i]));
            hi[i] = longint'($signed(setup.hi[i]));
            c[i]  = pt[i] - lo[i];
            if (!(lo[i] - tol <= pt[i] && pt[i] <= hi[i] + tol)) r.inside_res = 1'b0;
         end
         case (cls)
            aaspt_pkg::CLS_LINE, aaspt_pkg::CLS_QUAD, aaspt_pkg::CLS_HEX: begin
            end
            aaspt_pkg::CLS_PRISM: begin
               r.inside_res &= half_plane(c, 0, 1, orient, tol);
            end
            aaspt_pkg::CLS_TRI: begin
               flat = 1'b1;
               a    = 0;
               b    = 1;
               if (lo[2] == hi[2]) begin
                  a = 0;
                  b = 1;
               end else if (lo[1] == hi[1]) begin
                  a = 0;
                  b = 2;
               end else if (lo[0] == hi[0]) begin
                  a = 1;
                  b = 2;
               end else begin
                  flat = 1'b0;
               end
               if (!flat) begin
                  r.shape_error = 1'b1;
                  r.inside_res  = 1'b0;
               end else begin
                  r.inside_res &= half_plane(c, a, b, orient, tol);
               end
            end
            aaspt_pkg::CLS_TET: begin
               if (etype >= 3'd6) etype = etype - 3'd6;
               t = lvl0 ? int'(tree) : TYPE_REMAP[tree][etype];
               for (int s = 0; s < 2; s++) begin
                  r.inside_res &= half_plane(c, PLANE_AXIS[FACE_PLANE[t][s]][0],
                                             PLANE_AXIS[FACE_PLANE[t][s]][1],
                                             FACE_FORM[t][s], tol);
               end
            end
            default: begin
               r.shape_error = 1'b1;
               r.inside_res  = 1'b0;
            end
         endcase
         return r;
      endfunction

      function void note_point(aaspt_pkg::req_type p);
         points_q.push_back(p);
         verdicts_q.push_back(containment_of(p));
      endfunction

      function void check_verdict(aaspt_pkg::rsp_type got);
         aaspt_pkg::rsp_type want;
         aaspt_pkg::req_type p;
         if (verdicts_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: in=%b err=%b end=%b",
                        got.inside_res, got.shape_error, got.batch_end_out);
            return;
         end
         want = verdicts_q.pop_front();
         p    = points_q.pop_front();
         if (got.inside_res !== want.inside_res || got.shape_error !== want.shape_error ||
             got.batch_end_out !== want.batch_end_out) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch pt %h %h %h code %h: want in/err/end %b%b%b got %b%b%b",
                        p.point_x, p.point_y, p.point_z, setup.code,
                        want.inside_res, want.shape_error, want.batch_end_out,
                        got.inside_res, got.shape_error, got.batch_end_out);
         end
      endfunction
   endclass

   logic                             clock        = 1'b0;
   logic                             reset        = 1'b1;
   logic                             req_valid    = 1'b0;
   logic                             req_stall;
   aaspt_pkg::req_type               req_data     = '0;
   logic                             rsp_valid;
   logic                             rsp_stall    = 1'b0;
   aaspt_pkg::rsp_type               rsp_data;
   logic                             csr_write    = 1'b0;
   logic [2:0]                       csr_index    = aaspt_pkg::REG_MIN_X;
   logic [aaspt_pkg::FIELD_BITS-1:0] csr_wdata    = '0;
   bit                               idle_on      = 1'b1;
   bit                               hold_results = 1'b0;
   int                               points_sent  = 0;
   ledger_type                       ledger;

   axis_aligned_simplex_point_test dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) ledger.note_point(req_data);
         if (rsp_valid && !rsp_stall) ledger.check_verdict(rsp_data);
      end
   end

   // hold off results: a long stretch on request, short random bursts when idle_on is set
   initial begin : result_sink
      int held;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_stall <= 1'b1;
            held = 0;
            while (held < 80) begin
               @(posedge clock);
               held++;
            end
            hold_results = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic longint clamp_coord(longint v);
      if (v < COORD_LOW) return COORD_LOW;
      if (v > COORD_HIGH) return COORD_HIGH;
      return v;
   endfunction

   function automatic aaspt_pkg::req_type make_point(longint x, longint y, longint z,
                                                     bit last);
      aaspt_pkg::req_type p;
      p.point_x   = x[31:0];
      p.point_y   = y[31:0];
      p.point_z   = z[31:0];
      p.batch_end = last;
      return p;
   endfunction

   function automatic logic [9:0] shape_word(logic [2:0] cls, logic [2:0] tree,
                                            logic [2:0] etype, bit lvl0);
      return {lvl0, etype, tree, cls};
   endfunction

   function automatic setup_type make_element(longint lx, longint ly, longint lz,
                                              longint hx, longint hy, longint hz,
                                              logic [30:0] tol, logic [9:0] code);
      setup_type s;
      s.lo[0] = lx[31:0];
      s.lo[1] = ly[31:0];
      s.lo[2] = lz[31:0];
      s.hi[0] = hx[31:0];
      s.hi[1] = hy[31:0];
      s.hi[2] = hz[31:0];
      s.slack = tol;
      s.code  = code;
      return s;
   endfunction

   function automatic setup_type random_element();
      setup_type s;
      longint    base;
      longint    top;
      s.code = 10'($urandom_range(0, 1023));
      if (s.code[2:0] > aaspt_pkg::CLS_PRISM && $urandom_range(0, 1) == 0)
         s.code[2:0] = ($urandom_range(0, 1) == 0) ? aaspt_pkg::CLS_TET
                                                   : aaspt_pkg::CLS_TRI;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               s.lo[i] = $urandom;
               s.hi[i] = $urandom;
            end
            1: begin
               s.lo[i] = 32'h8000_0000;
               s.hi[i] = 32'h7fff_ffff;
            end
            default: begin
               base    = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh10_0000;
               top     = base + longint'($urandom_range(0, 32'h0008_0000));
               s.lo[i] = base[31:0];
               s.hi[i] = top[31:0];
            end
         endcase
      end
      if (s.code[2:0] == aaspt_pkg::CLS_TRI && $urandom_range(0, 3) != 0) begin
         base = longint'($urandom_range(0, 2));
         s.hi[base] = s.lo[base];
      end
      case ($urandom_range(0, 5))
         0:       s.slack = '0;
         1:       s.slack = 31'h7fff_ffff;
         2:       s.slack = 31'($urandom_range(0, 32'h7fff_ffff));
         default: s.slack = 31'($urandom_range(0, 32'h2000));
      endcase
      return s;
   endfunction

   function automatic aaspt_pkg::req_type near_point(setup_type s);
      longint v[3];
      longint lo;
      longint hi;
      longint tmp;
      longint tol;
      longint span;
      longint off;
      int     a;
      int     b;
      tol = longint'(s.slack);
      for (int i = 0; i < 3; i++) begin
         lo = longint'($signed(s.lo[i]));
         hi = longint'($signed(s.hi[i]));
         if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
         end
         case ($urandom_range(0, 7))
            0: v[i] = lo - tol - longint'($urandom_range(0, 1));
            1: v[i] = hi + tol + longint'($urandom_range(0, 1));
            2: v[i] = longint'($signed($urandom));
            default: begin
               span = hi - lo + 2 * tol + 64;
               v[i] = lo - tol - 32 + longint'({$urandom, $urandom} % span);
            end
         endcase
      end
      // land on or next to a diagonal face
      if ($urandom_range(0, 3) == 0) begin
         a = $urandom_range(0, 2);
         b = (a + $urandom_range(1, 2)) % 3;
         case ($urandom_range(0, 4))
            0:       off = -tol - 1;
            1:       off = -tol;
            2:       off = 0;
            3:       off = tol;
            default: off = tol + 1;
         endcase
         v[b] = longint'($signed(s.lo[b])) + v[a] - longint'($signed(s.lo[a])) + off;
      end
      return make_point(clamp_coord(v[0]), clamp_coord(v[1]), clamp_coord(v[2]),
                        $urandom_range(0, 7) == 0);
   endfunction

   task automatic offer_point(aaspt_pkg::req_type p);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      points_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.verdicts_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_element(setup_type s);
      logic [aaspt_pkg::FIELD_BITS-1:0] word;
      for (int r = 0; r < 8; r++) begin
         word = $urandom;
         case (REG_ORDER[r])
            aaspt_pkg::REG_MIN_X: word = s.lo[0];
            aaspt_pkg::REG_MIN_Y: word = s.lo[1];
            aaspt_pkg::REG_MIN_Z: word = s.lo[2];
            aaspt_pkg::REG_MAX_X: word = s.hi[0];
            aaspt_pkg::REG_MAX_Y: word = s.hi[1];
            aaspt_pkg::REG_MAX_Z: word = s.hi[2];
            aaspt_pkg::REG_SLACK: word[30:0] = s.slack;
            default:              word[9:0] = s.code;
         endcase
         csr_write <= 1'b1;
         csr_index <= REG_ORDER[r];
         csr_wdata <= word;
         @(posedge clock);
      end
      csr_write <= 1'b0;
      ledger.setup = s;
      repeat (2) @(posedge clock);
   endtask

   task automatic run_element(setup_type s);
      settle();
      load_element(s);
   endtask

   initial begin : stimulus
      setup_type s;
      int        phase;
      int        batch;
      ledger = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_point(make_point(0, 0, 0, 1'b0));
      offer_point(make_point(1, 0, 0, 1'b1));

      run_element(make_element(-32'sh1_0000, -32'sh2_0000, 0, 32'sh3_0000, 32'sh2_0000,
                               32'sh1_8000, 31'h100,
                               shape_word(aaspt_pkg::CLS_HEX, 0, 0, 1'b0)));
      offer_point(make_point(-32'sh1_0100, -32'sh2_0100, -32'sh100, 1'b0));
      offer_point(make_point(-32'sh1_0101, 0, 32'sh100, 1'b0));
      offer_point(make_point(32'sh3_0100, 32'sh2_0100, 32'sh1_8100, 1'b1));
      offer_point(make_point(0, 0, 32'sh1_8101, 1'b0));
      offer_point(make_point(0, -32'sh2_0101, 32'sh8000, 1'b0));
      offer_point(make_point(COORD_LOW, COORD_LOW, COORD_LOW, 1'b1));
      offer_point(make_point(COORD_HIGH, COORD_HIGH, COORD_HIGH, 1'b0));

      // triangle flat in z, both orientations
      s = make_element(0, 0, 32'sh4000, 32'sh1_0000, 32'sh1_0000, 32'sh4000, '0,
                       shape_word(aaspt_pkg::CLS_TRI, 0, 0, 1'b0));
      run_element(s);
      offer_point(make_point(32'sh8000, 32'sh4000, 32'sh4000, 1'b0));
      offer_point(make_point(32'sh4000, 32'sh8000, 32'sh4000, 1'b1));
      s.code = shape_word(aaspt_pkg::CLS_TRI, 0, 1, 1'b0);
      run_element(s);
      offer_point(make_point(32'sh4000, 32'sh8000, 32'sh4000, 1'b0));

      // triangle flat in y, tree index past range; then flat in x, element type past range
      s = make_element(0, 32'sh5000, 0, 32'sh1_0000, 32'sh5000, 32'sh1_0000, 31'h40,
                       shape_word(aaspt_pkg::CLS_TRI, 7, 0, 1'b0));
      run_element(s);
      offer_point(near_point(s));
      s = make_element(32'sh2000, 0, 0, 32'sh2000, 32'sh1_0000, 32'sh1_0000, 31'h10,
                       shape_word(aaspt_pkg::CLS_TRI, 2, 7, 1'b0));
      run_element(s);
      offer_point(near_point(s));
      // triangle with no flat axis
      s = make_element(0, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, '0,
                       shape_word(aaspt_pkg::CLS_TRI, 0, 0, 1'b0));
      run_element(s);
      offer_point(make_point(32'sh8000, 32'sh4000, 32'sh4000, 1'b0));
      s.code = shape_word(aaspt_pkg::CLS_PRISM, 3, 0, 1'b0);
      run_element(s);
      offer_point(make_point(32'sh4000, 32'sh8000, 32'sh100, 1'b0));
      s.code = shape_word(aaspt_pkg::CLS_TET, 2, 0, 1'b1);
      run_element(s);
      offer_point(near_point(s));
      s.code = shape_word(aaspt_pkg::CLS_TET, 6, 7, 1'b0);
      run_element(s);
      offer_point(near_point(s));
      s.code = shape_word(aaspt_pkg::CLS_QUAD, 5, 3, 1'b1);
      run_element(s);
      offer_point(make_point(32'sh8000, 32'sh8000, 32'sh8000, 1'b1));
      s.code = 10'h3fe;
      run_element(s);
      offer_point(make_point(32'sh8000, 32'sh8000, 32'sh8000, 1'b0));
      s.code = 10'h007;
      run_element(s);
      offer_point(make_point(32'sh8000, 32'sh8000, 32'sh8000, 1'b1));

      // min above max, slack just bridging the gap
      run_element(make_element(32'sh100, 0, 0, 0, 32'sh10, 32'sh10, 31'h80,
                               shape_word(aaspt_pkg::CLS_HEX, 0, 0, 1'b0)));
      offer_point(make_point(32'sh80, 32'sh8, 32'sh8, 1'b0));

      run_element(make_element(COORD_LOW, COORD_LOW, COORD_LOW, COORD_HIGH, COORD_HIGH,
                               COORD_HIGH, 31'h7fff_ffff,
                               shape_word(aaspt_pkg::CLS_TET, 0, 0, 1'b1)));
      offer_point(make_point(COORD_LOW, COORD_LOW, COORD_LOW, 1'b0));
      offer_point(make_point(COORD_HIGH, COORD_HIGH, COORD_HIGH, 1'b1));

      phase = 0;
      while (points_sent < 1000) begin
         s = random_element();
         run_element(s);
         idle_on = ($urandom_range(0, 3) != 0);
         batch   = $urandom_range(10, 50);
         if (phase == 4) begin
            hold_results = 1'b1;
            batch        = 40;
         end
         repeat (batch) offer_point(near_point(s));
         phase++;
      end

      idle_on = 1'b0;
      s = random_element();
      run_element(s);
      repeat (150) offer_point(near_point(s));

      settle();
      if (ledger.mismatches == 0 && ledger.verdicts_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
